@@ design/sdspi_pkg.sv @@
// Package for the SD-card SPI-mode host sequencer.
// Holds word types, phase and code constants and the command byte function.
// No dependencies; every design file imports it.
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int WAKE_BYTES  = 10;
  localparam int BC_W = ($clog2(BLOCK_BYTES + 1) > 8) ? $clog2(BLOCK_BYTES + 1) : 8;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_XCHG  = 2'd3;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_RESET_ERR = 3'd2;
  localparam logic [2:0] ST_VOLT_ERR  = 3'd3;
  localparam logic [2:0] ST_APP_ERR   = 3'd4;
  localparam logic [2:0] ST_CMD_ERR   = 3'd5;
  localparam logic [2:0] ST_DATA_ERR  = 3'd6;

  localparam logic REG_POLL_LIMIT  = 1'b0;
  localparam logic REG_RESET_LIMIT = 1'b1;

  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] DATA_TOKEN  = 8'hFE;
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [2:0] RESP_ACCEPT = 3'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_CSEND, PH_CPOLL, PH_CEXTRA, PH_CBUSY, PH_RTOKEN, PH_RDATA,
    PH_RTAIL, PH_WGAP, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_WTAIL
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] block_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } seq_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_low;
    logic       need_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [2:0] status;
    logic       card_high_capacity;
    logic       busy_res;
  } seq_out_t;

  typedef struct packed {
    logic [7:0] response_poll_limit;
    logic [7:0] reset_try_limit;
  } cfg_t;

  function automatic logic [7:0] cmd_byte(input logic [5:0] code, input logic [31:0] addr,
                                          input logic [BC_W-1:0] k);
    logic [31:0] arg;
    logic [7:0]  b;
    arg = 32'h0;
    if (code == CMD8) begin
      arg = 32'h0000_01AA;
    end else if (code == CMD41) begin
      arg = 32'h4000_0000;
    end else if (code == CMD17 || code == CMD24) begin
      arg = addr;
    end
    case (k)
      BC_W'(0): b = CMD_START | {2'b00, code};
      BC_W'(1): b = arg[31:24];
      BC_W'(2): b = arg[23:16];
      BC_W'(3): b = arg[15:8];
      BC_W'(4): b = arg[7:0];
      default: begin
        if (code == CMD0) begin
          b = 8'h95;
        end else if (code == CMD8) begin
          b = 8'h87;
        end else begin
          b = 8'h00;
        end
      end
    endcase
    return b;
  endfunction

endpackage

@@ design/sdspi_seq.sv @@
// Sequencer core: phase register, counters and response store, with the
// next-state and result logic for one accepted word. Depends on sdspi_pkg.
module sdspi_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  sdspi_pkg::seq_in_t in_word,
  input  sdspi_pkg::cfg_t    cfg,
  output sdspi_pkg::seq_out_t result
);
  import sdspi_pkg::*;

  phase_t          phase, phase_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [7:0]      try_count, try_count_next;
  logic [7:0]      r1, r1_next;
  logic [7:0]      resp [1:4];
  logic [7:0]      resp_next [1:4];
  logic [5:0]      command_code, command_code_next;
  logic [31:0]     saved_block_addr, saved_block_addr_next;
  logic            high_capacity, high_capacity_next;

  logic [BC_W-1:0] bc_inc;
  logic [7:0]      r1_cur;
  logic [7:0]      tc_sat;
  logic            do_cdone;
  logic            do_start;
  logic [5:0]      start_code;
  logic            do_finish;
  logic [2:0]      finish_status;
  seq_out_t        o;

  assign bc_inc = byte_count + BC_W'(1);
  assign tc_sat = (try_count == 8'hFF) ? try_count : try_count + 8'd1;

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    try_count_next = try_count;
    r1_next = r1;
    resp_next = resp;
    command_code_next = command_code;
    saved_block_addr_next = saved_block_addr;
    high_capacity_next = high_capacity;
    r1_cur = r1;
    do_cdone = 1'b0;
    do_start = 1'b0;
    start_code = CMD0;
    do_finish = 1'b0;
    finish_status = ST_NONE;
    o = '0;
    o.tx_byte = IDLE_BYTE;

    unique case (in_word.operation)
      OP_INIT: begin
        high_capacity_next = 1'b0;
        try_count_next = 8'd0;
        phase_next = PH_WAKE;
        byte_count_next = BC_W'(1);
        o.tx_valid = 1'b1;
      end
      OP_READ, OP_WRITE: begin
        saved_block_addr_next = in_word.block_addr;
        do_start = 1'b1;
        start_code = (in_word.operation == OP_READ) ? CMD17 : CMD24;
      end
      default: begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_WAKE: begin
            if (byte_count < BC_W'(WAKE_BYTES)) begin
              byte_count_next = bc_inc;
              o.tx_valid = 1'b1;
            end else begin
              do_start = 1'b1;
              start_code = CMD0;
            end
          end
          PH_CSEND: begin
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
            if (byte_count < BC_W'(6)) begin
              o.tx_byte = cmd_byte(command_code, saved_block_addr, byte_count);
              byte_count_next = bc_inc;
            end else begin
              byte_count_next = '0;
              phase_next = PH_CPOLL;
            end
          end
          PH_CPOLL: begin
            byte_count_next = bc_inc;
            r1_next = in_word.rx_byte;
            r1_cur = in_word.rx_byte;
            if (in_word.rx_byte[7]) begin
              if (bc_inc >= BC_W'(cfg.response_poll_limit)) begin
                do_cdone = 1'b1;
              end else begin
                o.tx_valid = 1'b1;
                o.chip_select_low = 1'b1;
              end
            end else if (command_code == CMD0 && !in_word.rx_byte[0]) begin
              do_cdone = 1'b1;
            end else if (command_code == CMD8 || command_code == CMD58) begin
              phase_next = PH_CEXTRA;
              byte_count_next = BC_W'(1);
              o.tx_valid = 1'b1;
              o.chip_select_low = 1'b1;
            end else begin
              phase_next = PH_CBUSY;
              o.tx_valid = 1'b1;
              o.chip_select_low = 1'b1;
            end
          end
          PH_CEXTRA: begin
            for (int i = 1; i <= 4; i++) begin
              if (byte_count == BC_W'(i)) begin
                resp_next[i] = in_word.rx_byte;
              end
            end
            byte_count_next = bc_inc;
            if (bc_inc >= BC_W'(5)) begin
              phase_next = PH_CBUSY;
            end
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
          end
          PH_CBUSY: begin
            if (in_word.rx_byte == 8'h00) begin
              o.tx_valid = 1'b1;
              o.chip_select_low = 1'b1;
            end else begin
              do_cdone = 1'b1;
            end
          end
          PH_RTOKEN: begin
            if (in_word.rx_byte == DATA_TOKEN) begin
              phase_next = PH_RDATA;
              byte_count_next = '0;
            end
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
          end
          PH_RDATA: begin
            o.read_valid = 1'b1;
            o.read_byte = in_word.rx_byte;
            byte_count_next = bc_inc;
            if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
              phase_next = PH_RTAIL;
              byte_count_next = BC_W'(1);
            end
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
          end
          PH_RTAIL: begin
            if (byte_count < BC_W'(3)) begin
              byte_count_next = bc_inc;
              o.tx_valid = 1'b1;
              o.chip_select_low = 1'b1;
            end else begin
              do_finish = 1'b1;
              finish_status = ST_OK;
            end
          end
          PH_WGAP: begin
            phase_next = PH_WDATA;
            byte_count_next = '0;
            o.tx_valid = 1'b1;
            o.tx_byte = DATA_TOKEN;
            o.chip_select_low = 1'b1;
            o.need_write_byte = 1'b1;
          end
          PH_WDATA: begin
            o.tx_valid = 1'b1;
            o.tx_byte = in_word.write_byte;
            o.chip_select_low = 1'b1;
            byte_count_next = bc_inc;
            if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
              phase_next = PH_WCRC;
              byte_count_next = '0;
            end else begin
              o.need_write_byte = 1'b1;
            end
          end
          PH_WCRC: begin
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
            if (byte_count < BC_W'(2)) begin
              byte_count_next = bc_inc;
              o.tx_byte = 8'h00;
            end else begin
              phase_next = PH_WRESP;
            end
          end
          PH_WRESP: begin
            if (in_word.rx_byte[3:1] != RESP_ACCEPT) begin
              do_finish = 1'b1;
              finish_status = ST_DATA_ERR;
            end else begin
              phase_next = PH_WBUSY;
              o.tx_valid = 1'b1;
              o.chip_select_low = 1'b1;
            end
          end
          PH_WBUSY: begin
            if (in_word.rx_byte != 8'h00) begin
              phase_next = PH_WTAIL;
            end
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
          end
          PH_WTAIL: begin
            do_finish = 1'b1;
            finish_status = ST_OK;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    endcase

    if (do_cdone) begin
      unique case (command_code)
        CMD0: begin
          try_count_next = tc_sat;
          if (r1_cur == 8'h01) begin
            do_start = 1'b1;
            start_code = CMD8;
          end else if (tc_sat >= cfg.reset_try_limit) begin
            do_finish = 1'b1;
            finish_status = ST_RESET_ERR;
          end else begin
            do_start = 1'b1;
            start_code = CMD0;
          end
        end
        CMD8: begin
          if (r1_cur == 8'h01 && !(resp[1] == 8'h00 && resp[2] == 8'h00 &&
                                   resp[3] == 8'h01 && resp[4] == 8'hAA)) begin
            do_finish = 1'b1;
            finish_status = ST_VOLT_ERR;
          end else begin
            do_start = 1'b1;
            start_code = (r1_cur != 8'h00) ? CMD55 : CMD58;
          end
        end
        CMD55: begin
          if (r1_cur != 8'h01) begin
            do_finish = 1'b1;
            finish_status = ST_APP_ERR;
          end else begin
            do_start = 1'b1;
            start_code = CMD41;
          end
        end
        CMD41: begin
          do_start = 1'b1;
          start_code = (r1_cur != 8'h00) ? CMD55 : CMD58;
        end
        CMD58: begin
          high_capacity_next = resp[1][6];
          do_finish = 1'b1;
          finish_status = ST_OK;
        end
        CMD17, CMD24: begin
          if (r1_cur != 8'h00) begin
            do_finish = 1'b1;
            finish_status = ST_CMD_ERR;
          end else begin
            phase_next = (command_code == CMD17) ? PH_RTOKEN : PH_WGAP;
            o.tx_valid = 1'b1;
            o.chip_select_low = 1'b1;
          end
        end
        default: begin
          do_finish = 1'b1;
          finish_status = ST_NONE;
        end
      endcase
    end

    if (do_start) begin
      command_code_next = start_code;
      r1_next = IDLE_BYTE;
      for (int i = 1; i <= 4; i++) begin
        resp_next[i] = 8'h00;
      end
      phase_next = PH_CSEND;
      byte_count_next = BC_W'(1);
      o.tx_valid = 1'b1;
      o.tx_byte = CMD_START | {2'b00, start_code};
      o.chip_select_low = 1'b1;
    end

    if (do_finish) begin
      phase_next = PH_IDLE;
      o.tx_valid = 1'b0;
      o.tx_byte = IDLE_BYTE;
      o.chip_select_low = 1'b0;
      o.done_res = 1'b1;
      o.status = finish_status;
    end

    o.card_high_capacity = high_capacity_next;
    o.busy_res = (phase_next != PH_IDLE);
  end

  assign result = o;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_count <= '0;
      try_count <= 8'd0;
      r1 <= 8'd0;
      for (int i = 1; i <= 4; i++) begin
        resp[i] <= 8'd0;
      end
      command_code <= CMD0;
      saved_block_addr <= 32'd0;
      high_capacity <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      try_count <= try_count_next;
      r1 <= r1_next;
      resp <= resp_next;
      command_code <= command_code_next;
      saved_block_addr <= saved_block_addr_next;
      high_capacity <= high_capacity_next;
    end
  end

endmodule

@@ design/sd_card_spi_host_sequencer_top.sv @@
// Top level of the SD-card SPI-mode host sequencer: configuration registers,
// input handshake and the result register. Depends on sdspi_pkg and sdspi_seq.

// Each input word is one SPI byte exchange (or a start command) and yields
// exactly one result word, registered and shown the cycle after acceptance.
// The block takes one word per clock cycle; in_ready drops only while a result
// is held in the output register and out_ready is low. Configuration writes
// go through the APB port at byte addresses 0 (poll limit) and 4 (reset tries).
module sd_card_spi_host_sequencer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdspi_pkg::seq_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sdspi_pkg::seq_out_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sdspi_pkg::*;

  cfg_t     cfg;
  seq_out_t result;
  logic     accept;
  logic     cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_poll_limit <= 8'd100;
      cfg.reset_try_limit <= 8'd100;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_POLL_LIMIT:  cfg.response_poll_limit <= pwdata[7:0];
        REG_RESET_LIMIT: cfg.reset_try_limit <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLL_LIMIT:  prdata = {24'd0, cfg.response_poll_limit};
      REG_RESET_LIMIT: prdata = {24'd0, cfg.reset_try_limit};
      default:         prdata = 32'd0;
    endcase
  end

  sdspi_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_word),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result;
    end
  end

  a_done_deselects: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.done_res |-> !out_word.tx_valid && !out_word.chip_select_low)
    else $error("Sequence end must not request an exchange or select the card.");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.tx_valid |-> out_word.tx_byte == IDLE_BYTE &&
    !out_word.chip_select_low)
    else $error("No exchange requested but the byte or select is active.");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_NONE |-> out_word.done_res && !out_word.busy_res)
    else $error("Status reported outside the end of a sequence.");

  a_need_byte_selected: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.need_write_byte |-> out_word.tx_valid &&
    out_word.chip_select_low && out_word.busy_res)
    else $error("Write data requested outside a selected exchange.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a waiting result.");

endmodule
